@@ sv/ps2_set1_scancode_to_ascii_core_assert.svh @@
// Assertion macros for the PS/2 set 1 scan code translator.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef PS2_SET1_SCANCODE_TO_ASCII_CORE_ASSERT_SVH
`define PS2_SET1_SCANCODE_TO_ASCII_CORE_ASSERT_SVH

// property holds in the same cycle
`define PS2S1ASC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PS2S1ASC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ps2s1asc_pkg.sv @@
// Shared types, key codes and character tables for the scan code translator.
// No dependencies.
package ps2s1asc_pkg;

	// keys at or above this number produce no character
	localparam int unsigned TABLE_ENTRIES = 88;

	localparam logic [6:0] SC_LCTRL  = 7'h1D;
	localparam logic [6:0] SC_LSHIFT = 7'h2A;
	localparam logic [6:0] SC_RSHIFT = 7'h36;
	localparam logic [6:0] SC_LALT   = 7'h38;
	localparam logic [6:0] SC_CAPS   = 7'h3A;

	typedef struct packed {
		logic [7:0] scan_byte;
	} scan_item_t;

	typedef struct packed {
		logic [6:0] ascii_code;
		logic       shift_down;
		logic       ctrl_down;
		logic       alt_down;
		logic       caps_on;
	} result_item_t;

	typedef struct packed {
		logic shift;
		logic ctrl;
		logic alt;
		logic caps;
	} mod_flags_t;

	// US layout, no modifier
	function automatic logic [6:0] plain_char(input logic [6:0] key);
		logic [6:0] c;
		case (key)
			7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;  7'h05: c = 7'h34;
			7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;  7'h09: c = 7'h38;
			7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;  7'h0D: c = 7'h3D;
			7'h0E: c = 7'h08;  7'h0F: c = 7'h09;
			7'h10: c = 7'h71;  7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;
			7'h14: c = 7'h74;  7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;
			7'h18: c = 7'h6F;  7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;
			7'h1C: c = 7'h0A;  7'h1E: c = 7'h61;  7'h1F: c = 7'h73;
			7'h20: c = 7'h64;  7'h21: c = 7'h66;  7'h22: c = 7'h67;  7'h23: c = 7'h68;
			7'h24: c = 7'h6A;  7'h25: c = 7'h6B;  7'h26: c = 7'h6C;  7'h27: c = 7'h3B;
			7'h28: c = 7'h27;  7'h29: c = 7'h60;  7'h2B: c = 7'h5C;
			7'h2C: c = 7'h7A;  7'h2D: c = 7'h78;  7'h2E: c = 7'h63;  7'h2F: c = 7'h76;
			7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;  7'h33: c = 7'h2C;
			7'h34: c = 7'h2E;  7'h35: c = 7'h2F;  7'h37: c = 7'h2A;  7'h39: c = 7'h20;
			// keypad
			7'h47: c = 7'h37;  7'h48: c = 7'h38;  7'h49: c = 7'h39;  7'h4A: c = 7'h2D;
			7'h4B: c = 7'h34;  7'h4C: c = 7'h35;  7'h4D: c = 7'h36;  7'h4E: c = 7'h2B;
			7'h4F: c = 7'h31;  7'h50: c = 7'h32;  7'h51: c = 7'h33;  7'h52: c = 7'h30;
			7'h53: c = 7'h2E;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	// US layout with shift; covers the main block only
	function automatic logic [6:0] shifted_char(input logic [5:0] key);
		logic [6:0] c;
		case (key)
			6'h02: c = 7'h21;  6'h03: c = 7'h40;  6'h04: c = 7'h23;  6'h05: c = 7'h24;
			6'h06: c = 7'h25;  6'h07: c = 7'h5E;  6'h08: c = 7'h26;  6'h09: c = 7'h2A;
			6'h0A: c = 7'h28;  6'h0B: c = 7'h29;  6'h0C: c = 7'h5F;  6'h0D: c = 7'h2B;
			6'h0E: c = 7'h08;  6'h0F: c = 7'h09;
			6'h10: c = 7'h51;  6'h11: c = 7'h57;  6'h12: c = 7'h45;  6'h13: c = 7'h52;
			6'h14: c = 7'h54;  6'h15: c = 7'h59;  6'h16: c = 7'h55;  6'h17: c = 7'h49;
			6'h18: c = 7'h4F;  6'h19: c = 7'h50;  6'h1A: c = 7'h7B;  6'h1B: c = 7'h7D;
			6'h1C: c = 7'h0A;  6'h1E: c = 7'h41;  6'h1F: c = 7'h53;
			6'h20: c = 7'h44;  6'h21: c = 7'h46;  6'h22: c = 7'h47;  6'h23: c = 7'h48;
			6'h24: c = 7'h4A;  6'h25: c = 7'h4B;  6'h26: c = 7'h4C;  6'h27: c = 7'h3A;
			6'h28: c = 7'h22;  6'h29: c = 7'h7E;  6'h2B: c = 7'h7C;
			6'h2C: c = 7'h5A;  6'h2D: c = 7'h58;  6'h2E: c = 7'h43;  6'h2F: c = 7'h56;
			6'h30: c = 7'h42;  6'h31: c = 7'h4E;  6'h32: c = 7'h4D;  6'h33: c = 7'h3C;
			6'h34: c = 7'h3E;  6'h35: c = 7'h3F;  6'h37: c = 7'h2A;  6'h39: c = 7'h20;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

@@ sv/ps2s1asc_chan_if.sv @@
// Valid/ready channel carrying one payload item per transfer.
// The payload type is given at instantiation.
interface ps2s1asc_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/ps2s1asc_xlate.sv @@
// Combinational scan code decode: modifier flag update and table lookup.
// Depends on ps2s1asc_pkg.
module ps2s1asc_xlate #(
	parameter int unsigned TABLE_ENTRIES = ps2s1asc_pkg::TABLE_ENTRIES
) (
	input  logic [7:0]               scan_byte,
	input  ps2s1asc_pkg::mod_flags_t flags,
	output logic [6:0]               ascii_code,
	output ps2s1asc_pkg::mod_flags_t flags_nxt
);
	import ps2s1asc_pkg::*;

	logic       released;
	logic [6:0] key;
	logic [6:0] c;

	assign released = scan_byte[7];
	assign key      = scan_byte[6:0];

	always_comb begin
		flags_nxt  = flags;
		ascii_code = 7'h00;
		c          = 7'h00;
		case (key)
			SC_LSHIFT, SC_RSHIFT: flags_nxt.shift = !released;
			SC_LCTRL:             flags_nxt.ctrl  = !released;
			SC_LALT:              flags_nxt.alt   = !released;
			SC_CAPS: begin
				if (!released)
					flags_nxt.caps = !flags.caps;
			end
			default: begin
				if (!released && ({1'b0, key} < 8'(TABLE_ENTRIES))) begin
					// shifted table ends at 0x3F; keypad keys use the plain one
					if (flags.shift && !key[6])
						c = shifted_char(key[5:0]);
					else
						c = plain_char(key);
					if (flags.caps && (c inside {[7'h41:7'h5A], [7'h61:7'h7A]}))
						c[5] = !c[5];
					ascii_code = c;
				end
			end
		endcase
	end
endmodule

@@ sv/ps2_set1_scancode_to_ascii_core.sv @@
// Top level of the PS/2 set 1 scan code to ASCII translator.
// Depends on ps2s1asc_pkg, ps2s1asc_chan_if, ps2s1asc_xlate and the assert macro header.
//
//   channel  modport  payload        per transfer
//   scan     sink     scan_item_t    one raw scan byte
//   result   source   result_item_t  ascii_code and modifier flags
//
// One byte per cycle sustained while result.ready stays high.
// Input register (_s1), then table lookup and flag update into the result register (_s2).
// Modifier flags advance when a byte moves from _s1 into the result register.
// arst_n clears the flags and both valid bits; payload registers are not reset.
// A stalled result holds the result register; scan.ready drops once _s1 is also full.
`include "ps2_set1_scancode_to_ascii_core_assert.svh"

module ps2_set1_scancode_to_ascii_core #(
	parameter int unsigned TABLE_ENTRIES = ps2s1asc_pkg::TABLE_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	ps2s1asc_chan_if.sink    scan,
	ps2s1asc_chan_if.source  result
);
	import ps2s1asc_pkg::*;

	logic         valid_s1;
	logic [7:0]   scan_byte_s1;
	logic         valid_s2;
	result_item_t result_s2;
	mod_flags_t   flags_q;
	mod_flags_t   flags_nxt;
	logic [6:0]   ascii_nxt;
	logic         load_s1;
	logic         load_s2;
	logic         flags_match;
	logic         caps_press;

	assign load_s2    = valid_s1 && (!valid_s2 || result.ready);
	assign scan.ready = !valid_s1 || load_s2;
	assign load_s1    = scan.valid && scan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1)
			scan_byte_s1 <= scan.data.scan_byte;
	end

	ps2s1asc_xlate #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_xlate (
		.scan_byte  (scan_byte_s1),
		.flags      (flags_q),
		.ascii_code (ascii_nxt),
		.flags_nxt  (flags_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s2) begin
				flags_q  <= flags_nxt;
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2.ascii_code <= ascii_nxt;
			result_s2.shift_down <= flags_nxt.shift;
			result_s2.ctrl_down  <= flags_nxt.ctrl;
			result_s2.alt_down   <= flags_nxt.alt;
			result_s2.caps_on    <= flags_nxt.caps;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = result_s2;

	assign flags_match = (result_s2.shift_down == flags_q.shift) &&
		(result_s2.ctrl_down == flags_q.ctrl) && (result_s2.alt_down == flags_q.alt) &&
		(result_s2.caps_on == flags_q.caps);
	assign caps_press  = load_s2 && (scan_byte_s1 == {1'b0, SC_CAPS});

	// the flags shown in a pending result are the live modifier state
	`PS2S1ASC_ASSERT(a_result_flags_live, !valid_s2 || flags_match, "result flags stale")
	// modifier state moves only with a byte leaving the input register
	`PS2S1ASC_ASSERT_NEXT(a_flags_hold, !load_s2, $stable(flags_q), "flags changed, no byte")
	// a caps lock press flips the lock state
	`PS2S1ASC_ASSERT_NEXT(a_caps_toggle, caps_press, $changed(flags_q.caps), "caps not toggled")
	// backpressure only while the input register holds a byte
	`PS2S1ASC_ASSERT(a_ready_low_full, scan.ready || valid_s1, "scan.ready low, s1 empty")
endmodule
